@@ rtl/atp_pkg.sv @@
// Shared types and constants for the attribute token parser.
// Token kind, role, completion and status codes, plus the parser phase type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package atp_pkg;

   localparam int IndexWidth = 16;
   localparam int KindWidth  = 4;

   typedef enum logic [3:0] {
      KIND_OTHER  = 4'd0,
      KIND_AT     = 4'd1,
      KIND_IDENT  = 4'd2,
      KIND_LPAREN = 4'd3,
      KIND_RPAREN = 4'd4,
      KIND_EQUAL  = 4'd5,
      KIND_COMMA  = 4'd6,
      KIND_STRING = 4'd7,
      KIND_NUMBER = 4'd8,
      KIND_FALSE  = 4'd9,
      KIND_TRUE   = 4'd10,
      KIND_SLASH  = 4'd11,
      KIND_STAR   = 4'd12,
      KIND_PLUS   = 4'd13,
      KIND_MINUS  = 4'd14
   } kind_type;

   typedef enum logic [2:0] {
      ROLE_OUTSIDE = 3'd0,
      ROLE_MARKER  = 3'd1,
      ROLE_NAME    = 3'd2,
      ROLE_OPEN    = 3'd3,
      ROLE_CLOSE   = 3'd4,
      ROLE_ELEMENT = 3'd5
   } role_type;

   typedef enum logic [1:0] {
      DONE_NONE   = 2'd0,
      DONE_BEFORE = 2'd1,
      DONE_WITH   = 2'd2
   } done_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_NAME  = 2'd1,
      STATUS_BAD_PARAM = 2'd2,
      STATUS_OVERFLOW  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      PHASE_SEARCH    = 4'b0001,
      PHASE_NAME      = 4'b0010,
      PHASE_LIST_OPEN = 4'b0100,
      PHASE_IN_LIST   = 4'b1000
   } phase_type;

   typedef struct packed {
      phase_type phase;
      logic      halted;
   } ctrl_type;

   typedef struct packed {
      role_type   role;
      done_type   done;
      status_type status;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/attribute_token_parser.sv @@
// Top level of the attribute token parser: input register, parser state and
// result register. Depends on atp_pkg and atp_step.
//
// Tokens arrive on the req_ channel, one transaction per classified token,
// and each produces exactly one transaction on the rsp_ channel carrying the
// echoed index, the token's role, attribute completion and an error status.
// A transaction is taken at a rising edge where valid is high and stall is low.
// A token is captured in the input register; once the result register is free,
// its result is written to the result register while the parser phase,
// parenthesis depth and halt flag are updated.
// Throughput is one token per cycle while rsp_stall is low; the only loop is
// the state update in the step logic. The input register keeps filling while
// a result waits to be taken, so req_stall rises only when both registers are
// full and rsp_stall is high. A stalled result holds its value.
// Reset clears both valid flags, puts the parser in the marker search phase,
// zeroes the depth and clears the halt flag. A token with start_of_stream set
// does the same for the parser state, not the valid flags, before it is handled.
`timescale 1ns / 1ps
`default_nettype none

module attribute_token_parser
   import atp_pkg::*;
#(
   parameter int MAX_DEPTH = 15
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [KindWidth-1:0]  req_token_kind,
   input  wire logic [IndexWidth-1:0] req_token_index,
   input  wire logic                  req_start_of_stream,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [IndexWidth-1:0]      rsp_index_out,
   output logic [2:0]                 rsp_role,
   output logic [1:0]                 rsp_attr_done,
   output logic [1:0]                 rsp_status
);

   localparam int DepthBits = $clog2(MAX_DEPTH + 1);

   logic                  in_valid_ff;
   logic [KindWidth-1:0]  in_kind_ff;
   logic [IndexWidth-1:0] in_index_ff;
   logic                  in_sos_ff;

   ctrl_type              ctrl_ff;
   ctrl_type              ctrl_in;
   logic [DepthBits-1:0]  depth_ff;
   logic [DepthBits-1:0]  depth_in;

   logic                  out_valid_ff;
   logic [IndexWidth-1:0] out_index_ff;
   result_type            out_result_ff;
   result_type            result_in;

   logic                  out_free;
   logic                  advance;
   logic                  accept;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   atp_step #(
      .MAX_DEPTH (MAX_DEPTH),
      .DEPTH_BITS(DepthBits)
   ) u_step (
      .kind           (in_kind_ff),
      .start_of_stream(in_sos_ff),
      .ctrl_cur       (ctrl_ff),
      .depth_cur      (depth_ff),
      .ctrl_next      (ctrl_in),
      .depth_next     (depth_in),
      .result         (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_kind_ff  <= req_token_kind;
         in_index_ff <= req_token_index;
         in_sos_ff   <= req_start_of_stream;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.phase  <= PHASE_SEARCH;
         ctrl_ff.halted <= 1'b0;
         depth_ff       <= '0;
      end else if (advance) begin
         ctrl_ff  <= ctrl_in;
         depth_ff <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_index_ff  <= in_index_ff;
         out_result_ff <= result_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_index_out = out_index_ff;
   assign rsp_role      = out_result_ff.role;
   assign rsp_attr_done = out_result_ff.done;
   assign rsp_status    = out_result_ff.status;

endmodule

`default_nettype wire

@@ rtl/atp_step.sv @@
// Combinational next-state and result logic for one token of the parser.
// Depends on atp_pkg for the code and phase types.
`timescale 1ns / 1ps
`default_nettype none

module atp_step
   import atp_pkg::*;
#(
   parameter int MAX_DEPTH  = 15,
   parameter int DEPTH_BITS = 4
) (
   input  wire logic [KindWidth-1:0]  kind,
   input  wire logic                  start_of_stream,
   input  wire ctrl_type              ctrl_cur,
   input  wire logic [DEPTH_BITS-1:0] depth_cur,
   output ctrl_type                   ctrl_next,
   output logic [DEPTH_BITS-1:0]      depth_next,
   output result_type                 result
);

   localparam logic [DEPTH_BITS-1:0] MaxDepthVal = DEPTH_BITS'(MAX_DEPTH);
   localparam logic [DEPTH_BITS-1:0] DepthOne    = DEPTH_BITS'(1);

   ctrl_type                ctrl_base;
   logic [DEPTH_BITS-1:0]   depth_base;
   logic [DEPTH_BITS-1:0]   depth_dec;
   phase_type               scan_phase;
   logic                    opened;
   logic                    is_other;

   assign is_other = (kind == KIND_OTHER) || (kind > KIND_MINUS);

   always_comb begin
      ctrl_base  = ctrl_cur;
      depth_base = depth_cur;
      if (start_of_stream) begin
         ctrl_base.phase  = PHASE_SEARCH;
         ctrl_base.halted = 1'b0;
         depth_base       = '0;
      end

      ctrl_next     = ctrl_base;
      depth_next    = depth_base;
      depth_dec     = depth_base;
      result.role   = ROLE_OUTSIDE;
      result.done   = DONE_NONE;
      result.status = STATUS_OK;
      scan_phase    = ctrl_base.phase;
      opened        = 1'b0;

      if (!ctrl_base.halted) begin
         if (ctrl_base.phase == PHASE_LIST_OPEN) begin
            if (kind == KIND_LPAREN) begin
               result.role     = ROLE_OPEN;
               depth_next      = DepthOne;
               ctrl_next.phase = PHASE_IN_LIST;
               opened          = 1'b1;
            end else begin
               result.done     = DONE_BEFORE;
               ctrl_next.phase = PHASE_SEARCH;
               scan_phase      = PHASE_SEARCH;
            end
         end

         if (!opened) begin
            case (scan_phase)
               PHASE_SEARCH: begin
                  if (kind == KIND_AT) begin
                     result.role     = ROLE_MARKER;
                     ctrl_next.phase = PHASE_NAME;
                  end
               end
               PHASE_NAME: begin
                  if (kind == KIND_IDENT) begin
                     result.role     = ROLE_NAME;
                     ctrl_next.phase = PHASE_LIST_OPEN;
                  end else begin
                     result.status    = STATUS_BAD_NAME;
                     ctrl_next.halted = 1'b1;
                  end
               end
               PHASE_IN_LIST: begin
                  if (kind == KIND_RPAREN) begin
                     result.role = ROLE_CLOSE;
                     if (depth_base != '0) begin
                        depth_dec = depth_base - DepthOne;
                     end
                     depth_next = depth_dec;
                     if (depth_dec == '0) begin
                        result.done     = DONE_WITH;
                        ctrl_next.phase = PHASE_SEARCH;
                     end
                  end else if (kind == KIND_LPAREN) begin
                     if (depth_base >= MaxDepthVal) begin
                        result.status    = STATUS_OVERFLOW;
                        ctrl_next.halted = 1'b1;
                     end else begin
                        result.role = ROLE_OPEN;
                        depth_next  = depth_base + DepthOne;
                     end
                  end else if (is_other) begin
                     result.status    = STATUS_BAD_PARAM;
                     ctrl_next.halted = 1'b1;
                  end else begin
                     result.role = ROLE_ELEMENT;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

endmodule

`default_nettype wire
